### src/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, opcodes and slot type codes of the timed callback table.
// ----------------------------------------------------------------------------
package tct_pkg;

   localparam int DEF_SLOT_COUNT = 32;

   // field widths of the request and response beats
   localparam int OP_W     = 3;
   localparam int TIME_W   = 32;
   localparam int ID_W     = 16;
   localparam int ARG_W    = 32;
   localparam int PERIOD_W = 24;
   localparam int SLOT_W   = 6;
   localparam int STYPE_W  = 3;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 64;

   localparam logic [OP_W-1:0] OP_ALLOC_PER = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC_TMP = 3'd1;
   localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
   localparam logic [OP_W-1:0] OP_FREE      = 3'd3;
   localparam logic [OP_W-1:0] OP_EXECUTE   = 3'd4;
   localparam logic [OP_W-1:0] OP_STOP_ALL  = 3'd5;

   localparam logic [STYPE_W-1:0] T_START = 3'd0;
   localparam logic [STYPE_W-1:0] T_EXEC  = 3'd1;
   localparam logic [STYPE_W-1:0] T_TEMP  = 3'd2;
   localparam logic [STYPE_W-1:0] T_STOP  = 3'd3;
   localparam logic [STYPE_W-1:0] T_FREE  = 3'd4;

   localparam logic [0:0] KIND_ACK  = 1'b0;
   localparam logic [0:0] KIND_FIRE = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]     callback;
      logic [ARG_W-1:0]    arg;
      logic [STYPE_W-1:0]  stype;
      logic                has_handle;
      logic [TIME_W-1:0]   arm_time;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   next_time;
   } slot_entry_type;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [TIME_W-1:0]   now_time;
      logic [ID_W-1:0]     callback_id;
      logic [ARG_W-1:0]    callback_arg;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] start_delay;
      logic                handle_present;
      logic                handle_valid;
      logic [SLOT_W-1:0]   handle_slot;
   } req_item_type;

   // what the slot evaluator decides for the entry at hand
   typedef struct packed {
      logic           write;
      logic           set_valid;
      logic           clear_valid;
      logic           hit;
      logic           is_match;
      logic           emit;
      slot_entry_type wdata;
   } slot_upd_type;

endpackage

### src/timed_callback_table.sv
// ----------------------------------------------------------------------------
// timed_callback_table
// Table of timed callback slots held in one memory, walked a slot per cycle while no fire beat waits on the output.
//
//   channel  dir  tdata                          tuser         tlast
//   req      in   request fields, 136 bits       opcode        -
//   rsp      out  handle/fire fields, 64 bits    result kind   end of run
//
// Request accepted only when the sequencer is idle; while no fire beat
// waits on the output register, one slot is read and written back per
// cycle through the memory ports. Execute and stop_all walk every slot,
// alloc walks to a free or matching slot, stop and free touch at most the
// handle slot. Reset empties the table at once through per-slot valid
// flip-flops; the ack of an item may wait in the output register while
// the next request is taken.
// ----------------------------------------------------------------------------
module timed_callback_table
   import tct_pkg::*;
#(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_time[31:0], callback_id[47:32], callback_arg[79:48], period[103:80],
   // start_delay[127:104], handle_present[128], handle_valid[129],
   // handle_slot[135:130]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_slot[5:0], out_slot_valid[6], success[7], fire_callback_id[23:8],
   // fire_arg[55:24], fire_type[58:56], fire_uses_caller_handle[59], zero[63:60]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result_kind[0]
   output logic [0:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int ENTRY_W = $bits(slot_entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W-1:0] FIRST_ALLOC_IDX = IDX_W'(1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HRD  = 3'd1;
   localparam logic [2:0] S_HCHK = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_ACK  = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic                  vld_q_ff, vld_q_in;
   req_item_type          item_ff, item_in;
   logic [SLOT_W-1:0]     ack_slot_ff, ack_slot_in;
   logic                  ack_valid_ff, ack_valid_in;
   logic                  ack_succ_ff, ack_succ_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   req_item_type          req_item;
   logic                  req_accept;
   logic                  out_free;
   logic                  rsp_load;
   logic                  in_range;
   logic                  go;
   logic                  is_alloc;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   logic                  ram_re;
   logic [IDX_W-1:0]      ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   slot_entry_type        entry;
   slot_upd_type          upd;

   assign req_item.opcode         = req_tuser;
   assign req_item.now_time       = req_tdata[31:0];
   assign req_item.callback_id    = req_tdata[47:32];
   assign req_item.callback_arg   = req_tdata[79:48];
   assign req_item.period         = req_tdata[103:80];
   assign req_item.start_delay    = req_tdata[127:104];
   assign req_item.handle_present = req_tdata[128];
   assign req_item.handle_valid   = req_tdata[129];
   assign req_item.handle_slot    = req_tdata[135:130];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_range   = ({1'b0, req_item.handle_slot} < (SLOT_W + 1)'(SLOT_COUNT));
   assign is_alloc   = (item_ff.opcode == OP_ALLOC_PER) || (item_ff.opcode == OP_ALLOC_TMP);
   assign entry      = slot_entry_type'(ram_rdata);

   tct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ENTRY_W'(upd.wdata)),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   tct_slot_alu u_slot_alu (
      .item        (item_ff),
      .hchk        (state_ff == S_HCHK),
      .entry       (entry),
      .entry_valid (vld_q_ff),
      .upd         (upd)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rd_valid_in  = rd_valid_ff;
      item_in      = item_ff;
      ack_slot_in  = ack_slot_ff;
      ack_valid_in = ack_valid_ff;
      ack_succ_in  = ack_succ_ff;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff;
      ram_re       = 1'b0;
      ram_raddr    = cur_ff;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      go           = 1'b0;
      valid_in     = valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               item_in      = req_item;
               rd_valid_in  = 1'b0;
               ack_slot_in  = req_item.handle_present ? req_item.handle_slot : '0;
               ack_valid_in = req_item.handle_present && req_item.handle_valid;
               ack_succ_in  = 1'b0;
               cur_in       = req_item.handle_slot[IDX_W-1:0];
               unique case (req_item.opcode) inside
                  OP_ALLOC_PER: begin
                     if (req_item.callback_id == '0 || req_item.period == '0) begin
                        state_in = S_ACK;
                     end else if (req_item.handle_present && req_item.handle_valid &&
                                  in_range) begin
                        state_in = S_HRD;
                     end else begin
                        cur_in   = FIRST_ALLOC_IDX;
                        state_in = S_SCAN;
                     end
                  end
                  OP_ALLOC_TMP: begin
                     ack_slot_in  = '0;
                     ack_valid_in = 1'b0;
                     cur_in       = FIRST_ALLOC_IDX;
                     state_in     = (req_item.callback_id == '0) ? S_ACK : S_SCAN;
                  end
                  OP_STOP, OP_FREE: begin
                     if (req_item.handle_present && req_item.handle_valid) begin
                        ack_succ_in = 1'b1;
                        if (req_item.opcode == OP_STOP) begin
                           ack_slot_in  = '0;
                           ack_valid_in = 1'b0;
                        end
                     end
                     state_in = (req_item.handle_present && req_item.handle_valid &&
                                 in_range) ? S_HRD : S_ACK;
                  end
                  OP_EXECUTE, OP_STOP_ALL: begin
                     ack_slot_in  = '0;
                     ack_valid_in = 1'b0;
                     cur_in       = '0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                     ack_slot_in  = '0;
                     ack_valid_in = 1'b0;
                     state_in     = S_ACK;
                  end
               endcase
            end
         end
         S_HRD: begin
            ram_re   = 1'b1;
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (is_alloc) begin
               if (upd.hit) begin
                  state_in = S_ACK;
               end else begin
                  cur_in      = FIRST_ALLOC_IDX;
                  rd_valid_in = 1'b0;
                  state_in    = S_SCAN;
               end
            end else begin
               ram_we   = upd.write;
               state_in = S_ACK;
            end
         end
         S_SCAN: begin
            if (!rd_valid_ff) begin
               ram_re      = 1'b1;
               rd_valid_in = 1'b1;
            end else begin
               // a fire beat holds the walk until the output register frees
               go = !upd.emit || out_free;
               if (go) begin
                  ram_we = upd.write;
                  if (upd.set_valid) begin
                     valid_in[cur_ff] = 1'b1;
                  end else if (upd.clear_valid) begin
                     valid_in[cur_ff] = 1'b0;
                  end
                  if (upd.emit) begin
                     rsp_load    = 1'b1;
                     rsp_user_in = KIND_FIRE;
                     rsp_last_in = 1'b0;
                     rsp_data_in = {4'b0, upd.wdata.has_handle, entry.stype, entry.arg,
                                    entry.callback, 1'b0, 1'b1, SLOT_W'(cur_ff)};
                  end
                  if (is_alloc && upd.hit) begin
                     if (item_ff.opcode == OP_ALLOC_TMP ||
                         (!upd.is_match && item_ff.handle_present)) begin
                        ack_slot_in  = SLOT_W'(cur_ff);
                        ack_valid_in = 1'b1;
                     end
                     state_in = S_ACK;
                  end else if (cur_ff == LAST_IDX) begin
                     if (is_alloc && item_ff.handle_present) begin
                        ack_slot_in  = '0;
                        ack_valid_in = 1'b0;
                     end
                     state_in = S_ACK;
                  end else begin
                     // next slot is read while this one is written back
                     cur_in    = cur_ff + IDX_W'(1);
                     ram_re    = 1'b1;
                     ram_raddr = cur_ff + IDX_W'(1);
                  end
               end
            end
         end
         S_ACK: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_user_in = KIND_ACK;
               rsp_last_in = 1'b1;
               rsp_data_in = {56'b0, ack_succ_ff, ack_valid_ff, ack_slot_ff};
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      vld_q_in = ram_re ? valid_ff[ram_raddr] : vld_q_ff;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         vld_q_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rd_valid_ff  <= rd_valid_in;
         valid_ff     <= valid_in;
         vld_q_ff     <= vld_q_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      ack_slot_ff  <= ack_slot_in;
      ack_valid_ff <= ack_valid_in;
      ack_succ_ff  <= ack_succ_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      ram_we && ram_re |-> ram_waddr != ram_raddr)
      else $error("slot read and write back hit the same entry");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_valid_ff |-> rsp_tready)
      else $error("output register overwritten while held");

   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_SCAN || state_ff == S_HCHK)
      else $error("slot memory written outside walk or handle check");

   a_ack_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_last_in |=> state_ff == S_IDLE && rsp_tvalid && rsp_tlast)
      else $error("ack beat did not close the item");
`endif

endmodule

### src/tct_ram.sv
// ----------------------------------------------------------------------------
// tct_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module tct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/tct_slot_alu.sv
// ----------------------------------------------------------------------------
// tct_slot_alu
// Evaluates one slot entry against the current request: allocation search,
// handle check, stop/free retype, execute due test and stop-all rewrite.
// ----------------------------------------------------------------------------
module tct_slot_alu
   import tct_pkg::*;
(
   input  req_item_type   item,
   input  logic           hchk,
   input  slot_entry_type entry,
   input  logic           entry_valid,
   output slot_upd_type   upd
);

   logic                occupied;
   logic                same_cb;
   logic                due;
   logic [TIME_W-1:0]   advanced;
   slot_entry_type      fill;

   always_comb begin
      occupied = entry_valid && (entry.callback != '0);
      same_cb  = entry_valid && (entry.callback == item.callback_id) &&
                 (entry.arg == item.callback_arg);
      due      = occupied && (entry.stype != T_FREE) &&
                 !(entry.arm_time > item.now_time) &&
                 !(entry.next_time > item.now_time);
      advanced = entry.next_time + TIME_W'(entry.period);

      fill.callback   = item.callback_id;
      fill.arg        = item.callback_arg;
      fill.arm_time   = item.now_time + TIME_W'(item.start_delay);
      fill.next_time  = item.now_time + TIME_W'(item.start_delay);
      if (item.opcode == OP_ALLOC_PER) begin
         fill.stype      = T_START;
         fill.has_handle = item.handle_present;
         fill.period     = item.period;
      end else begin
         fill.stype      = T_TEMP;
         fill.has_handle = 1'b0;
         fill.period     = '0;
      end

      upd.write       = 1'b0;
      upd.set_valid   = 1'b0;
      upd.clear_valid = 1'b0;
      upd.hit         = 1'b0;
      upd.is_match    = 1'b0;
      upd.emit        = 1'b0;
      upd.wdata       = entry;

      unique case (item.opcode) inside
         OP_ALLOC_PER, OP_ALLOC_TMP: begin
            if (hchk) begin
               // caller handle already points at a live slot
               upd.hit = occupied;
            end else begin
               upd.is_match  = same_cb;
               upd.hit       = same_cb || !occupied;
               upd.write     = !same_cb && !occupied;
               upd.set_valid = !same_cb && !occupied;
               upd.wdata     = fill;
            end
         end
         OP_STOP, OP_FREE: begin
            // an empty slot never fires, so its type need not be kept
            upd.write       = entry_valid;
            upd.wdata.stype = (item.opcode == OP_STOP) ? T_STOP : T_FREE;
         end
         OP_EXECUTE: begin
            upd.emit = due && (!entry.has_handle || (advanced > item.now_time));
            if (due) begin
               if (entry.stype == T_TEMP || entry.stype == T_STOP) begin
                  upd.clear_valid = 1'b1;
               end else begin
                  upd.write           = 1'b1;
                  upd.wdata.next_time = advanced;
                  if (entry.stype == T_START) begin
                     upd.wdata.stype = T_EXEC;
                  end
               end
            end
         end
         OP_STOP_ALL: begin
            upd.write           = occupied;
            upd.wdata.next_time = item.now_time;
            upd.wdata.stype     = T_STOP;
         end
         default: begin
            upd.write = 1'b0;
         end
      endcase
   end

endmodule
